### sv/srsc_pkg.sv
// Shared constants, types and register codes for the scissor rectangle scale-and-clip block.
package srsc_pkg;
  localparam int CoordW = 13;
  localparam int RectW  = 15;
  localparam int OutW   = 14;
  localparam int EdgeW  = 15;
  localparam int NumW   = 27;
  localparam int QuoW   = 13;
  localparam int Lanes  = 4;
  localparam int FrontStages = 3;
  localparam int BackStages  = 2;
  localparam int Latency = FrontStages + QuoW + BackStages;

  typedef enum logic [2:0] {
    CfgScreenW = 3'd0,
    CfgScreenH = 3'd1,
    CfgViewX   = 3'd2,
    CfgViewY   = 3'd3,
    CfgViewW   = 3'd4,
    CfgViewH   = 3'd5
  } cfg_idx_e;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [NumW-1:0] num_t;
  typedef logic [QuoW-1:0] quo_t;

  typedef struct packed {
    logic   empty;
    logic   clip_active;
    coord_t cx;
    coord_t cy;
    coord_t cw;
    coord_t ch;
  } side_t;

  typedef struct packed {
    coord_t screen_w;
    coord_t screen_h;
    coord_t view_x;
    coord_t view_y;
    coord_t view_w;
    coord_t view_h;
  } cfg_t;
endpackage

### sv/srsc_front.sv
// Front pipeline: edge clamping, empty detection, scaling products and division numerators.
module srsc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [srsc_pkg::RectW-1:0] rect_left_i,
  input  logic signed [srsc_pkg::RectW-1:0] rect_top_i,
  input  logic signed [srsc_pkg::RectW-1:0] rect_right_i,
  input  logic signed [srsc_pkg::RectW-1:0] rect_bottom_i,
  input  srsc_pkg::side_t               side_i,
  input  srsc_pkg::cfg_t                cfg_i,
  output logic                          valid_o,
  output srsc_pkg::side_t               side_o,
  output srsc_pkg::num_t [srsc_pkg::Lanes-1:0] num_o
);
  import srsc_pkg::*;

  logic signed [RectW:0] sw_hi, sh_hi;
  coord_t lc, rc, tc, bc;
  logic   empty_c;
  side_t  side_c;

  logic   v0_q, v1_q, v2_q;
  side_t  s0_q, s1_q, s2_q;
  coord_t l0_q, r0_q, t0_q, b0_q;
  logic [2*CoordW:0] p_q [Lanes];
  num_t  n_q [Lanes];

  function automatic coord_t clamp_f(logic signed [RectW-1:0] v, logic signed [RectW:0] hi);
    logic signed [RectW:0] w;
    w = {v[RectW-1], v};
    if (w < 0) return '0;
    else if (w > hi) return coord_t'(hi);
    else return coord_t'(w);
  endfunction

  always_comb begin
    sw_hi = $signed({3'b0, cfg_i.screen_w}) - 16'sd1;
    sh_hi = $signed({3'b0, cfg_i.screen_h}) - 16'sd1;
    lc = clamp_f(rect_left_i, sw_hi);
    rc = clamp_f(rect_right_i, sw_hi);
    tc = clamp_f(rect_top_i, sh_hi);
    bc = clamp_f(rect_bottom_i, sh_hi);
    empty_c = (cfg_i.screen_w == '0) || (cfg_i.screen_h == '0) ||
              (rect_right_i < rect_left_i) || (rect_bottom_i < rect_top_i) ||
              (rc < lc) || (bc < tc);
    side_c       = side_i;
    side_c.empty = empty_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= side_c;
    l0_q <= lc;
    r0_q <= rc;
    t0_q <= tc;
    b0_q <= bc;
    // scale: far edges take one past the inclusive pixel
    s1_q   <= s0_q;
    p_q[0] <= (2*CoordW+1)'(l0_q) * (2*CoordW+1)'(cfg_i.view_w);
    p_q[1] <= ((2*CoordW+1)'(r0_q) + 1'b1) * (2*CoordW+1)'(cfg_i.view_w);
    p_q[2] <= (2*CoordW+1)'(t0_q) * (2*CoordW+1)'(cfg_i.view_h);
    p_q[3] <= ((2*CoordW+1)'(b0_q) + 1'b1) * (2*CoordW+1)'(cfg_i.view_h);
    // bias the ceiling numerators
    s2_q   <= s1_q;
    n_q[0] <= NumW'(p_q[0]);
    n_q[1] <= NumW'(p_q[1]) + NumW'(cfg_i.screen_w) - NumW'(1);
    n_q[2] <= NumW'(p_q[2]);
    n_q[3] <= NumW'(p_q[3]) + NumW'(cfg_i.screen_h) - NumW'(1);
  end

  assign valid_o = v2_q;
  assign side_o  = s2_q;
  always_comb begin
    for (int i = 0; i < Lanes; i++) num_o[i] = n_q[i];
  end
endmodule

### sv/srsc_div.sv
// Pipelined restoring divider: four lanes, one quotient bit per stage.
module srsc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  srsc_pkg::side_t               side_i,
  input  srsc_pkg::num_t [srsc_pkg::Lanes-1:0] num_i,
  input  srsc_pkg::coord_t              div_x_i,
  input  srsc_pkg::coord_t              div_y_i,
  output logic                          valid_o,
  output srsc_pkg::side_t               side_o,
  output srsc_pkg::quo_t [srsc_pkg::Lanes-1:0] quo_o
);
  import srsc_pkg::*;

  logic  v_q   [QuoW+1];
  side_t s_q   [QuoW+1];
  num_t  rem_q [QuoW+1][Lanes];
  quo_t  quo_q [QuoW+1][Lanes];

  always_comb begin
    v_q[0] = valid_i;
    s_q[0] = side_i;
    for (int i = 0; i < Lanes; i++) begin
      rem_q[0][i] = num_i[i];
      quo_q[0][i] = '0;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    localparam int Sh = QuoW - 1 - k;
    num_t rem_d [Lanes];
    quo_t quo_d [Lanes];
    num_t dsh   [Lanes];

    always_comb begin
      for (int i = 0; i < Lanes; i++) begin
        dsh[i] = NumW'((i < 2) ? div_x_i : div_y_i) << Sh;
        rem_d[i] = rem_q[k][i];
        quo_d[i] = quo_q[k][i];
        if (rem_q[k][i] >= dsh[i]) begin
          rem_d[i] = rem_q[k][i] - dsh[i];
          quo_d[i][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k+1] <= 1'b0;
      else         v_q[k+1] <= v_q[k];
    end

    always_ff @(posedge clk_i) begin
      s_q[k+1] <= s_q[k];
      for (int i = 0; i < Lanes; i++) begin
        rem_q[k+1][i] <= rem_d[i];
        quo_q[k+1][i] <= quo_d[i];
      end
    end
  end

  assign valid_o = v_q[QuoW];
  assign side_o  = s_q[QuoW];
  always_comb begin
    for (int i = 0; i < Lanes; i++) quo_o[i] = quo_q[QuoW][i];
  end
endmodule

### sv/srsc_back.sv
// Back pipeline: viewport offset, Y flip, scissor intersection and size.
module srsc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  srsc_pkg::side_t               side_i,
  input  srsc_pkg::quo_t [srsc_pkg::Lanes-1:0] quo_i,
  input  srsc_pkg::cfg_t                cfg_i,
  output logic                          valid_o,
  output logic [srsc_pkg::OutW-1:0]     box_x_o,
  output logic [srsc_pkg::OutW-1:0]     box_y_o,
  output logic [srsc_pkg::OutW-1:0]     box_w_o,
  output logic [srsc_pkg::OutW-1:0]     box_h_o
);
  import srsc_pkg::*;

  typedef logic [EdgeW-1:0] edge_t;

  logic  va_q, vb_q;
  side_t sa_q;
  edge_t x1_q, x2_q, y1_q, y2_q, cx2_q, cy2_q;
  edge_t x1, x2, y1, y2;
  logic [OutW-1:0] bx_q, by_q, bw_q, bh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q  <= side_i;
    x1_q  <= EdgeW'(cfg_i.view_x) + EdgeW'(quo_i[0]);
    x2_q  <= EdgeW'(cfg_i.view_x) + EdgeW'(quo_i[1]);
    y1_q  <= EdgeW'(cfg_i.view_y) + EdgeW'(cfg_i.view_h) - EdgeW'(quo_i[3]);
    y2_q  <= EdgeW'(cfg_i.view_y) + EdgeW'(cfg_i.view_h) - EdgeW'(quo_i[2]);
    cx2_q <= EdgeW'(side_i.cx) + EdgeW'(side_i.cw);
    cy2_q <= EdgeW'(side_i.cy) + EdgeW'(side_i.ch);
  end

  always_comb begin
    x1 = x1_q;
    x2 = x2_q;
    y1 = y1_q;
    y2 = y2_q;
    if (sa_q.clip_active) begin
      if (EdgeW'(sa_q.cx) > x1) x1 = EdgeW'(sa_q.cx);
      if (EdgeW'(sa_q.cy) > y1) y1 = EdgeW'(sa_q.cy);
      if (cx2_q < x2) x2 = cx2_q;
      if (cy2_q < y2) y2 = cy2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sa_q.empty) begin
      // degenerate: zero box at the viewport origin
      bx_q <= OutW'(cfg_i.view_x);
      by_q <= OutW'(cfg_i.view_y);
      bw_q <= '0;
      bh_q <= '0;
    end else begin
      bx_q <= OutW'(x1);
      by_q <= OutW'(y1);
      bw_q <= (x2 > x1) ? OutW'(x2 - x1) : '0;
      bh_q <= (y2 > y1) ? OutW'(y2 - y1) : '0;
    end
  end

  assign valid_o = vb_q;
  assign box_x_o = bx_q;
  assign box_y_o = by_q;
  assign box_w_o = bw_q;
  assign box_h_o = bh_q;
endmodule

### sv/scissor_rect_scale_clip_top.sv
// Top level of the scissor rectangle scale-and-clip pipeline with its register file.
// A rectangle is taken on every cycle that start is high (busy stays low), and its scissor box
// appears on the box ports with done_o high after three front stages (clamp, multiply, bias),
// thirteen divider stages producing one quotient bit each, and two back stages (offset and
// intersect). Results cannot be held off, so capture them on done_o.
// Write registers only while no transaction is in flight.
module scissor_rect_scale_clip_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [srsc_pkg::RectW-1:0] rect_left_i,
  input  logic signed [srsc_pkg::RectW-1:0] rect_top_i,
  input  logic signed [srsc_pkg::RectW-1:0] rect_right_i,
  input  logic signed [srsc_pkg::RectW-1:0] rect_bottom_i,
  input  logic                          clip_active_i,
  input  logic [srsc_pkg::CoordW-1:0]   clip_x_i,
  input  logic [srsc_pkg::CoordW-1:0]   clip_y_i,
  input  logic [srsc_pkg::CoordW-1:0]   clip_w_i,
  input  logic [srsc_pkg::CoordW-1:0]   clip_h_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [srsc_pkg::CoordW-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic [srsc_pkg::OutW-1:0]     box_x_o,
  output logic [srsc_pkg::OutW-1:0]     box_y_o,
  output logic [srsc_pkg::OutW-1:0]     box_w_o,
  output logic [srsc_pkg::OutW-1:0]     box_h_o
);
  import srsc_pkg::*;

  cfg_t  cfg_q;
  side_t side_in, side_f, side_d;
  logic  valid_f, valid_d;
  num_t [Lanes-1:0] num_f;
  quo_t [Lanes-1:0] quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_w <= CoordW'(640);
      cfg_q.screen_h <= CoordW'(480);
      cfg_q.view_x   <= '0;
      cfg_q.view_y   <= '0;
      cfg_q.view_w   <= CoordW'(640);
      cfg_q.view_h   <= CoordW'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScreenW: cfg_q.screen_w <= cfg_data_i;
        CfgScreenH: cfg_q.screen_h <= cfg_data_i;
        CfgViewX:   cfg_q.view_x   <= cfg_data_i;
        CfgViewY:   cfg_q.view_y   <= cfg_data_i;
        CfgViewW:   cfg_q.view_w   <= cfg_data_i;
        CfgViewH:   cfg_q.view_h   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  always_comb begin
    side_in.empty       = 1'b0;
    side_in.clip_active = clip_active_i;
    side_in.cx          = clip_x_i;
    side_in.cy          = clip_y_i;
    side_in.cw          = clip_w_i;
    side_in.ch          = clip_h_i;
  end

  srsc_front u_front (
    .clk_i, .rst_ni,
    .valid_i      (start && !busy),
    .rect_left_i, .rect_top_i, .rect_right_i, .rect_bottom_i,
    .side_i       (side_in),
    .cfg_i        (cfg_q),
    .valid_o      (valid_f),
    .side_o       (side_f),
    .num_o        (num_f)
  );

  srsc_div u_div (
    .clk_i, .rst_ni,
    .valid_i (valid_f),
    .side_i  (side_f),
    .num_i   (num_f),
    .div_x_i (cfg_q.screen_w),
    .div_y_i (cfg_q.screen_h),
    .valid_o (valid_d),
    .side_o  (side_d),
    .quo_o   (quo_d)
  );

  srsc_back u_back (
    .clk_i, .rst_ni,
    .valid_i (valid_d),
    .side_i  (side_d),
    .quo_i   (quo_d),
    .cfg_i   (cfg_q),
    .valid_o (done_o),
    .box_x_o, .box_y_o, .box_w_o, .box_h_o
  );
endmodule

### sv/srsc_checker.sv
// Port-level checks for the scale-and-clip pipeline, bound to the top level.
module srsc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic [srsc_pkg::OutW-1:0] box_x_o,
  input logic [srsc_pkg::OutW-1:0] box_w_o
);
  import srsc_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised on a fully pipelined block");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, Latency))
    else $error("result without a matching transaction");

  a_start_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(Latency) (done_o || !rst_ni))
    else $error("transaction lost in the pipeline");

  a_box_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({1'b0, box_x_o} + {1'b0, box_w_o}) < (OutW+1)'(1 << OutW))
    else $error("box extends past the coordinate range");
endmodule

bind scissor_rect_scale_clip_top srsc_checker u_srsc_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .box_x_o, .box_w_o
);

### sim/scissor_box_checker.sv
// Checker for the scissor box pipeline: predicts each box and compares it on done_o.
`timescale 1ns / 100ps
module scissor_box_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  input  logic                               busy,
  input  logic signed [srsc_pkg::RectW-1:0]  rect_left_i,
  input  logic signed [srsc_pkg::RectW-1:0]  rect_top_i,
  input  logic signed [srsc_pkg::RectW-1:0]  rect_right_i,
  input  logic signed [srsc_pkg::RectW-1:0]  rect_bottom_i,
  input  logic                               clip_active_i,
  input  logic [srsc_pkg::CoordW-1:0]        clip_x_i,
  input  logic [srsc_pkg::CoordW-1:0]        clip_y_i,
  input  logic [srsc_pkg::CoordW-1:0]        clip_w_i,
  input  logic [srsc_pkg::CoordW-1:0]        clip_h_i,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [srsc_pkg::CoordW-1:0]        cfg_data_i,
  input  logic                               done_o,
  input  logic [srsc_pkg::OutW-1:0]          box_x_o,
  input  logic [srsc_pkg::OutW-1:0]          box_y_o,
  input  logic [srsc_pkg::OutW-1:0]          box_w_o,
  input  logic [srsc_pkg::OutW-1:0]          box_h_o,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import srsc_pkg::*;

  typedef struct packed {
    logic [OutW-1:0] x;
    logic [OutW-1:0] y;
    logic [OutW-1:0] w;
    logic [OutW-1:0] h;
  } scissor_box_t;

  cfg_t         view_cfg;
  scissor_box_t expected_boxes[$];
  int           mismatches;

  function automatic scissor_box_t scale_and_clip(
    logic signed [RectW-1:0] left, logic signed [RectW-1:0] top,
    logic signed [RectW-1:0] right, logic signed [RectW-1:0] bottom,
    logic act, coord_t cx, coord_t cy, coord_t cw, coord_t ch);
    longint l, t, r, b, sw, sh, vx, vy, vw, vh, x1, x2, y1, y2, top_e, bot_e;
    scissor_box_t res;
    l = left; t = top; r = right; b = bottom;
    sw = view_cfg.screen_w; sh = view_cfg.screen_h;
    vx = view_cfg.view_x; vy = view_cfg.view_y;
    vw = view_cfg.view_w; vh = view_cfg.view_h;
    res.x = vx[OutW-1:0];
    res.y = vy[OutW-1:0];
    res.w = '0;
    res.h = '0;
    if (sw == 0 || sh == 0 || r < l || b < t) return res;
    l = (l < 0) ? 0 : (l > sw - 1) ? sw - 1 : l;
    r = (r < 0) ? 0 : (r > sw - 1) ? sw - 1 : r;
    t = (t < 0) ? 0 : (t > sh - 1) ? sh - 1 : t;
    b = (b < 0) ? 0 : (b > sh - 1) ? sh - 1 : b;
    // clamping keeps edge order; a rectangle lying wholly off one side collapses onto that edge
    if (r < l || b < t) return res;
    x1 = vx + (l * vw) / sw;
    x2 = vx + ((r + 1) * vw + sw - 1) / sw;
    top_e = (t * vh) / sh;
    bot_e = ((b + 1) * vh + sh - 1) / sh;
    y1 = vy + vh - bot_e;
    y2 = vy + vh - top_e;
    if (act) begin
      if (cx > x1) x1 = cx;
      if (cy > y1) y1 = cy;
      if (longint'(cx) + cw < x2) x2 = longint'(cx) + cw;
      if (longint'(cy) + ch < y2) y2 = longint'(cy) + ch;
    end
    res.x = x1[OutW-1:0];
    res.y = y1[OutW-1:0];
    res.w = (x2 > x1) ? OutW'(x2 - x1) : '0;
    res.h = (y2 > y1) ? OutW'(y2 - y1) : '0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scissor_box_t seen, want;
    if (!rst_ni) begin
      view_cfg <= '{screen_w: 640, screen_h: 480, view_x: 0, view_y: 0,
                    view_w: 640, view_h: 480};
      expected_boxes.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgScreenW: view_cfg.screen_w <= cfg_data_i;
          CfgScreenH: view_cfg.screen_h <= cfg_data_i;
          CfgViewX:   view_cfg.view_x   <= cfg_data_i;
          CfgViewY:   view_cfg.view_y   <= cfg_data_i;
          CfgViewW:   view_cfg.view_w   <= cfg_data_i;
          CfgViewH:   view_cfg.view_h   <= cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy)
        expected_boxes.push_back(scale_and_clip(rect_left_i, rect_top_i, rect_right_i,
          rect_bottom_i, clip_active_i, clip_x_i, clip_y_i, clip_w_i, clip_h_i));
      if (done_o) begin
        seen = '{x: box_x_o, y: box_y_o, w: box_w_o, h: box_h_o};
        if (expected_boxes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected box x=%0d y=%0d w=%0d h=%0d",
            seen.x, seen.y, seen.w, seen.h);
        end else begin
          want = expected_boxes.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("box mismatch: expected x=%0d y=%0d w=%0d h=%0d, got x=%0d y=%0d w=%0d h=%0d",
                want.x, want.y, want.w, want.h, seen.x, seen.y, seen.w, seen.h);
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o <= expected_boxes.size();
    end
  end
endmodule

### sim/scissor_rect_scale_clip_top_tb.sv
// Testbench top for the scissor box pipeline: stimulus, configuration phases and verdict.
`timescale 1ns / 100ps
module scissor_rect_scale_clip_top_tb;
  import srsc_pkg::*;

  localparam int WatchdogLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [RectW-1:0] rect_left_i = '0, rect_top_i = '0;
  logic signed [RectW-1:0] rect_right_i = '0, rect_bottom_i = '0;
  logic clip_active_i = 1'b0;
  logic [CoordW-1:0] clip_x_i = '0, clip_y_i = '0, clip_w_i = '0, clip_h_i = '0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [CoordW-1:0] cfg_data_i = '0;
  logic done_o;
  logic [OutW-1:0] box_x_o, box_y_o, box_w_o, box_h_o;
  int fail_count, pending;
  int idle_cycles = 0;
  int scr_w = 640, scr_h = 480;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  scissor_rect_scale_clip_top dut (.*);

  scissor_box_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  // a long silence on both channels means the pipeline has hung
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // let the clock tick first so the count includes the last transaction
  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_rect(int l, int t, int r, int b, bit act, int cx, int cy, int cw, int ch);
    rect_left_i <= RectW'(l); rect_top_i <= RectW'(t);
    rect_right_i <= RectW'(r); rect_bottom_i <= RectW'(b);
    clip_active_i <= act;
    clip_x_i <= CoordW'(cx); clip_y_i <= CoordW'(cy);
    clip_w_i <= CoordW'(cw); clip_h_i <= CoordW'(ch);
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic set_view(int sw, int sh, int vx, int vy, int vw, int vh);
    cfg_idx_e idx;
    int vals[6];
    vals = '{sw, sh, vx, vy, vw, vh};
    start <= 1'b0;
    drain();
    repeat (Latency + 4) @(posedge clk_i);
    for (int i = 0; i < 6; i++) begin
      idx = cfg_idx_e'(i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= CoordW'(vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    scr_w = sw;
    scr_h = sh;
  endtask

  function automatic int edge_near(int span);
    return $urandom_range(span + 16) - 8;
  endfunction

  task automatic random_rects(int count);
    int l, t, r, b, burst, gap, kind;
    bit act;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        // hold off until the pipeline has emptied
        start <= 1'b0;
        drain();
      end
      kind = $urandom_range(99);
      if (kind < 15) begin
        l = $urandom; t = $urandom; r = $urandom; b = $urandom;
      end else begin
        l = edge_near(scr_w); r = edge_near(scr_w);
        t = edge_near(scr_h); b = edge_near(scr_h);
        if (kind < 85) begin
          if (r < l) begin r = r ^ l; l = r ^ l; r = r ^ l; end
          if (b < t) begin b = b ^ t; t = b ^ t; b = b ^ t; end
        end
      end
      act = $urandom_range(1);
      if ($urandom_range(1))
        send_rect(l, t, r, b, act, $urandom, $urandom, $urandom, $urandom);
      else
        send_rect(l, t, r, b, act, $urandom_range(800), $urandom_range(600),
                  $urandom_range(800), $urandom_range(600));
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end else begin
        burst--;
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed cases on the reset view
    send_rect(-16384, -16384, 16383, 16383, 1'b0, 8191, 8191, 8191, 8191);
    send_rect(0, 0, 639, 479, 1'b0, 0, 0, 0, 0);
    send_rect(10, 10, 9, 20, 1'b0, 0, 0, 0, 0);
    send_rect(10, 20, 30, 19, 1'b0, 0, 0, 0, 0);
    send_rect(700, 0, 800, 100, 1'b0, 0, 0, 0, 0);
    send_rect(-50, -50, -1, -1, 1'b0, 0, 0, 0, 0);
    send_rect(0, 500, 100, 600, 1'b0, 0, 0, 0, 0);
    send_rect(5, 5, 5, 5, 1'b0, 0, 0, 0, 0);
    send_rect(100, 100, 200, 200, 1'b1, 0, 0, 8191, 8191);
    send_rect(100, 100, 200, 200, 1'b1, 150, 300, 20, 20);
    send_rect(100, 100, 200, 200, 1'b1, 400, 0, 10, 10);
    send_rect(100, 100, 200, 200, 1'b1, 8191, 8191, 0, 0);
    send_rect(16383, 16383, 16383, 16383, 1'b0, 0, 0, 0, 0);
    send_rect(-16384, 0, 0, -16384, 1'b1, 1, 1, 1, 1);
    send_rect(639, 479, 639, 479, 1'b1, 0, 0, 0, 0);
    send_rect(0, 0, 16383, 16383, 1'b1, 8191, 0, 8191, 8191);
    random_rects(250);
    set_view(1, 1, 8191, 8191, 8191, 8191);
    send_rect(0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
    random_rects(150);
    set_view(8191, 8191, 0, 0, 8191, 8191);
    send_rect(0, 0, 8190, 8190, 1'b1, 8191, 8191, 8191, 8191);
    random_rects(250);
    set_view(0, 480, 123, 456, 640, 480);
    random_rects(80);
    set_view(640, 0, 8191, 0, 0, 0);
    random_rects(80);
    set_view(320, 200, 100, 50, 1280, 800);
    random_rects(300);
    set_view(7, 3, 8191, 0, 1, 8191);
    random_rects(250);
    set_view($urandom_range(1, 2000), $urandom_range(1, 2000), $urandom_range(8191),
             $urandom_range(8191), $urandom_range(8191), $urandom_range(8191));
    random_rects(330);
    drain();
    repeat (Latency + 4) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
